>>> sv/gec_pkg.sv
package gec_pkg;

    localparam int DOF_W    = 8;
    localparam int IDX_W    = 6;
    localparam int COLOR_W  = 6;
    localparam int CCOUNT_W = 7;
    localparam int NPE_W    = 3;
    localparam int TAG_W    = 8;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // register index taken from paddr above the byte offset
    localparam logic [0:0] REG_NPE = 1'b0;

    localparam logic [NPE_W-1:0] NPE_RESET = 3'd4;

    typedef struct packed {
        logic [DOF_W-1:0] dof_id;
        logic             last_item;
    } gec_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]    element_index;
        logic [COLOR_W-1:0]  color;
        logic [CCOUNT_W-1:0] color_count;
        logic                overflow;
        logic                last;
    } gec_out_t;

endpackage

>>> sv/gec_ram.sv
module gec_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/gec_apb.sv
module gec_apb
    import gec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [NPE_W-1:0]  npe
);

    logic [NPE_W-1:0] npe_reg;
    logic [NPE_W-1:0] npe_next;
    logic             sel_npe;

    assign sel_npe = (paddr[APB_AW-1] == REG_NPE);

    always_comb
    begin
        npe_next = npe_reg;
        if (psel && penable && pwrite && sel_npe)
        begin
            npe_next = pwdata[NPE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npe_reg <= NPE_RESET;
        end
        else
        begin
            npe_reg <= npe_next;
        end
    end

    assign prdata = sel_npe ? {{(APB_DW-NPE_W){1'b0}}, npe_reg} : '0;
    assign pready = 1'b1;
    assign npe    = npe_reg;

endmodule

>>> sv/greedy_element_coloring.sv
// Channel   Signals                            Accepted when
// config    psel penable pwrite paddr pwdata   psel & penable & pwrite (pready = 1)
// item in   start item                         start & !busy
// result    result_valid result                every cycle result_valid is high
//
// Load: one item per cycle while busy is low; a short final element is padded by
// repeating its last DOF. Coloring, per pass: an already colored element is skipped
// after its color store read, else its DOFs are checked against the DOF mask and marked
// there if it takes the color (node store read feeds the DOF mask read). Results leave
// back to back, one per cycle, then S_ELAST closes the set. After reset, and once every
// 255 passes, busy stays high while the DOF mask store is swept clean. Results cannot be held off.
module greedy_element_coloring
    import gec_pkg::*;
#(
    parameter int MAX_ELEMENTS          = 64,
    parameter int MAX_NODES_PER_ELEMENT = 4,
    parameter int DOF_COUNT             = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  gec_in_t           item,
    output logic              result_valid,
    output gec_out_t          result
);

    localparam int EW     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW     = $clog2(MAX_ELEMENTS + 1);
    localparam int NDEPTH = MAX_ELEMENTS * MAX_NODES_PER_ELEMENT;
    localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam int PW     = $clog2(MAX_NODES_PER_ELEMENT + 1);
    localparam int LW     = (MAX_NODES_PER_ELEMENT > 1) ? $clog2(MAX_NODES_PER_ELEMENT) : 1;
    localparam int MW     = $clog2(DOF_COUNT);
    localparam int CSW    = COLOR_W + 1;
    localparam logic [TAG_W-1:0] TAG_LAST = '1;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_FILL    = 12'b0000_0000_0010,
        S_CLEAR   = 12'b0000_0000_0100,
        S_CINIT   = 12'b0000_0000_1000,
        S_PASS    = 12'b0000_0001_0000,
        S_FLAG    = 12'b0000_0010_0000,
        S_FLAGCHK = 12'b0000_0100_0000,
        S_CHECK   = 12'b0000_1000_0000,
        S_MARK    = 12'b0001_0000_0000,
        S_ELEND   = 12'b0010_0000_0000,
        S_EMIT    = 12'b0100_0000_0000,
        S_ELAST   = 12'b1000_0000_0000
    } state_t;

    // configuration
    logic [NPE_W-1:0] npe_cfg;
    logic [PW-1:0]    npe_eff;

    // control state
    state_t            state_reg, state_next;
    logic [CW-1:0]     ecount_reg, ecount_next;
    logic [NAW-1:0]    base_reg, base_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     ccolor_reg, ccolor_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [MW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_ret_reg, clr_ret_next;
    logic [EW-1:0]     e_reg, e_next;
    logic [PW-1:0]     k_reg, k_next;
    logic              conflict_reg, conflict_next;
    logic              s1_vld_reg, s1_vld_next;
    logic              s2_vld_reg, s2_vld_next;
    logic              o_vld_reg, o_vld_next;

    // payload
    logic [DOF_W-1:0]  fill_dof_reg, fill_dof_next;
    logic [LW-1:0]     s1_k_reg, s1_k_next;
    logic [EW-1:0]     o_idx_reg, o_idx_next;
    logic              o_last_reg, o_last_next;
    logic [MW-1:0]     lane_reg [MAX_NODES_PER_ELEMENT];

    // memory ports
    logic              node_we;
    logic [NAW-1:0]    node_waddr, node_raddr;
    logic [DOF_W-1:0]  node_wdata, node_rdata;
    logic              mask_we;
    logic [MW-1:0]     mask_waddr, mask_raddr;
    logic [TAG_W-1:0]  mask_wdata, mask_rdata;
    logic              col_we;
    logic [EW-1:0]     col_waddr, col_raddr;
    logic [CSW-1:0]    col_wdata, col_rdata;

    logic              stored;
    logic [PW-1:0]     pos_inc;
    logic              elem_end;
    logic              first_pass;
    logic              last_elem;
    logic              adv;
    logic [MW-1:0]     dof_map [2**DOF_W];

    gec_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .npe     (npe_cfg)
    );

    gec_ram #(.WIDTH(DOF_W), .DEPTH(NDEPTH)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    gec_ram #(.WIDTH(TAG_W), .DEPTH(DOF_COUNT)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    gec_ram #(.WIDTH(CSW), .DEPTH(MAX_ELEMENTS)) u_color_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    // DOF number folded into the mask range
    for (genvar g = 0; g < 2**DOF_W; g++)
    begin : g_dof_map
        assign dof_map[g] = MW'(g % DOF_COUNT);
    end

    always_comb
    begin
        if (npe_cfg == '0)
        begin
            npe_eff = PW'(1);
        end
        else if (int'(npe_cfg) > MAX_NODES_PER_ELEMENT)
        begin
            npe_eff = PW'(MAX_NODES_PER_ELEMENT);
        end
        else
        begin
            npe_eff = PW'(npe_cfg);
        end
    end

    assign stored     = (ecount_reg < CW'(MAX_ELEMENTS));
    assign pos_inc    = pos_reg + PW'(1);
    assign elem_end   = (pos_inc >= npe_eff) || item.last_item;
    assign first_pass = (ccolor_reg == '0);
    assign last_elem  = ((CW'(e_reg) + CW'(1)) == ecount_reg);

    always_comb
    begin
        state_next    = state_reg;
        ecount_next   = ecount_reg;
        base_next     = base_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        ccolor_next   = ccolor_reg;
        remain_next   = remain_reg;
        tag_next      = tag_reg;
        clr_addr_next = clr_addr_reg;
        clr_ret_next  = clr_ret_reg;
        e_next        = e_reg;
        k_next        = k_reg;
        conflict_next = conflict_reg;
        s1_vld_next   = 1'b0;
        s2_vld_next   = 1'b0;
        o_vld_next    = 1'b0;
        fill_dof_next = fill_dof_reg;
        s1_k_next     = s1_k_reg;
        o_idx_next    = o_idx_reg;
        o_last_next   = o_last_reg;
        adv           = 1'b0;

        node_we    = 1'b0;
        node_waddr = base_reg + NAW'(pos_reg);
        node_wdata = item.dof_id;
        node_raddr = base_reg + NAW'(k_reg);
        mask_we    = 1'b0;
        mask_waddr = clr_addr_reg;
        mask_wdata = '0;
        mask_raddr = dof_map[node_rdata];
        col_we     = 1'b0;
        col_waddr  = e_reg;
        col_wdata  = {~conflict_reg, COLOR_W'(ccolor_reg)};
        col_raddr  = e_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    node_we  = stored;
                    pos_next = pos_inc;
                    if (elem_end)
                    begin
                        pos_next = '0;
                        if (!stored)
                        begin
                            ovf_next = 1'b1;
                        end
                        if (stored && (pos_inc < npe_eff))
                        begin
                            // short final element: repeat its last DOF
                            fill_dof_next = item.dof_id;
                            pos_next      = pos_inc;
                            state_next    = S_FILL;
                        end
                        else
                        begin
                            if (stored)
                            begin
                                ecount_next = ecount_reg + CW'(1);
                                base_next   = base_reg + NAW'(MAX_NODES_PER_ELEMENT);
                            end
                            if (item.last_item)
                            begin
                                state_next = S_CINIT;
                            end
                        end
                    end
                end
            end

            S_FILL:
            begin
                node_we    = 1'b1;
                node_wdata = fill_dof_reg;
                pos_next   = pos_inc;
                if (pos_inc == npe_eff)
                begin
                    pos_next    = '0;
                    ecount_next = ecount_reg + CW'(1);
                    base_next   = base_reg + NAW'(MAX_NODES_PER_ELEMENT);
                    state_next  = S_CINIT;
                end
            end

            S_CLEAR:
            begin
                mask_we       = 1'b1;
                clr_addr_next = clr_addr_reg + MW'(1);
                if (clr_addr_reg == MW'(DOF_COUNT - 1))
                begin
                    tag_next   = '0;
                    state_next = clr_ret_reg ? S_PASS : S_IDLE;
                end
            end

            S_CINIT:
            begin
                ccolor_next = '0;
                remain_next = ecount_reg;
                state_next  = S_PASS;
            end

            S_PASS:
            begin
                if (remain_reg == '0)
                begin
                    e_next     = '0;
                    state_next = (ecount_reg == '0) ? S_ELAST : S_EMIT;
                end
                else if (tag_reg == TAG_LAST)
                begin
                    // tags about to wrap: sweep the mask first
                    clr_addr_next = '0;
                    clr_ret_next  = 1'b1;
                    state_next    = S_CLEAR;
                end
                else
                begin
                    tag_next   = tag_reg + TAG_W'(1);
                    e_next     = '0;
                    base_next  = '0;
                    state_next = S_FLAG;
                end
            end

            S_FLAG:
            begin
                state_next = S_FLAGCHK;
            end

            S_FLAGCHK:
            begin
                if (!first_pass && col_rdata[COLOR_W])
                begin
                    adv = 1'b1;
                end
                else
                begin
                    k_next        = '0;
                    conflict_next = 1'b0;
                    state_next    = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (k_reg < npe_eff)
                begin
                    k_next      = k_reg + PW'(1);
                    s1_vld_next = 1'b1;
                    s1_k_next   = k_reg[LW-1:0];
                end
                s2_vld_next = s1_vld_reg;
                if (s2_vld_reg && (mask_rdata == tag_reg))
                begin
                    conflict_next = 1'b1;
                end
                if ((k_reg == npe_eff) && !s1_vld_reg && !s2_vld_reg)
                begin
                    k_next     = '0;
                    state_next = conflict_reg ? S_ELEND : S_MARK;
                end
            end

            S_MARK:
            begin
                mask_we    = 1'b1;
                mask_waddr = lane_reg[k_reg[LW-1:0]];
                mask_wdata = tag_reg;
                k_next     = k_reg + PW'(1);
                if ((k_reg + PW'(1)) == npe_eff)
                begin
                    state_next = S_ELEND;
                end
            end

            S_ELEND:
            begin
                // pass 0 writes every entry so the colored bit is defined later
                col_we = first_pass || !conflict_reg;
                if (!conflict_reg)
                begin
                    remain_next = remain_reg - CW'(1);
                end
                adv = 1'b1;
            end

            S_EMIT:
            begin
                o_vld_next  = 1'b1;
                o_idx_next  = e_reg;
                o_last_next = last_elem;
                if (last_elem)
                begin
                    state_next = S_ELAST;
                end
                else
                begin
                    e_next = e_reg + EW'(1);
                end
            end

            S_ELAST:
            begin
                ecount_next = '0;
                pos_next    = '0;
                ovf_next    = 1'b0;
                base_next   = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (last_elem)
            begin
                ccolor_next = ccolor_reg + CW'(1);
                state_next  = S_PASS;
            end
            else
            begin
                e_next     = e_reg + EW'(1);
                base_next  = base_reg + NAW'(MAX_NODES_PER_ELEMENT);
                state_next = S_FLAG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ecount_reg   <= '0;
            base_reg     <= '0;
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            ccolor_reg   <= '0;
            remain_reg   <= '0;
            tag_reg      <= '0;
            clr_addr_reg <= '0;
            clr_ret_reg  <= 1'b0;
            e_reg        <= '0;
            k_reg        <= '0;
            conflict_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            o_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ecount_reg   <= ecount_next;
            base_reg     <= base_next;
            pos_reg      <= pos_next;
            ovf_reg      <= ovf_next;
            ccolor_reg   <= ccolor_next;
            remain_reg   <= remain_next;
            tag_reg      <= tag_next;
            clr_addr_reg <= clr_addr_next;
            clr_ret_reg  <= clr_ret_next;
            e_reg        <= e_next;
            k_reg        <= k_next;
            conflict_reg <= conflict_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s2_vld_next;
            o_vld_reg    <= o_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_dof_reg <= fill_dof_next;
        s1_k_reg     <= s1_k_next;
        o_idx_reg    <= o_idx_next;
        o_last_reg   <= o_last_next;
        if (s1_vld_reg)
        begin
            lane_reg[s1_k_reg] <= dof_map[node_rdata];
        end
    end

    assign busy                 = (state_reg != S_IDLE);
    assign result_valid         = o_vld_reg;
    assign result.element_index = IDX_W'(o_idx_reg);
    assign result.color         = col_rdata[COLOR_W-1:0];
    assign result.color_count   = CCOUNT_W'(ccolor_reg);
    assign result.overflow      = ovf_reg;
    assign result.last          = o_last_reg;

endmodule

>>> sv/gec_chk.sv
module gec_chk
    import gec_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input gec_in_t  item,
    input logic     result_valid,
    input gec_out_t result
);

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_item) |=> busy)
        else $error("final item did not start coloring");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("gap inside result burst");

    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result after final element");

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, result.color} < result.color_count))
        else $error("color not below color count");

endmodule

bind greedy_element_coloring gec_chk u_gec_chk (.*);
